### sv/scpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared types and fixed-point constants for the sine/cosine polynomial block.
// ----------------------------------------------------------------------------
package scpa_pkg;

   typedef enum logic {
      OP_SINE   = 1'b0,
      OP_COSINE = 1'b1
   } op_type;

   localparam int DEF_PHASE_BITS    = 16;
   localparam int DEF_OUT_FRAC_BITS = 14;
   localparam int VALUE_W           = 16;

   // radians in Q28
   localparam int XF      = 28;
   localparam int TWOPI_W = 31;
   localparam int CQ_W    = 22;
   localparam int A_W     = 29;   // a  <= pi/2
   localparam int A2_W    = 30;   // a2 <= (pi/2)^2
   localparam int A3_W    = 30;   // a3 <= (pi/2)^3
   localparam int D_W     = 33;   // 20 - a2
   localparam int T_W     = 35;
   localparam int U_W     = 28;

   localparam logic [TWOPI_W-1:0] TWOPI_Q  = 31'd1686629713;
   localparam logic [CQ_W-1:0]    C_Q      = 22'd2228014;
   localparam logic [D_W-1:0]     TWENTY_Q = 33'd20 << XF;

   localparam int STAGES = 7;

endpackage

### sv/scpa_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_channels
// Request and response channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
interface scpa_req_if #(
   parameter int PHASE_BITS = scpa_pkg::DEF_PHASE_BITS
);
   logic                   valid;
   logic                   ready;
   scpa_pkg::op_type       op;
   logic [PHASE_BITS-1:0]  phase;

   modport source (output valid, output op, output phase, input ready);
   modport sink   (input valid, input op, input phase, output ready);
endinterface

interface scpa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [scpa_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

### sv/sine_cosine_poly_approx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_poly_approx
// Fifth-order odd polynomial sine/cosine on a quadrant-folded phase.
// ----------------------------------------------------------------------------
// One word is taken per clock while the response is not stalled. There are
// seven register stages, and the accepting edge loads the first: a fold
// stage, five multiply-and-round stages (radian scaling, x^2, x^3,
// x^3*(20-x^2), times the coefficient) and a final subtract, round and
// saturate stage that doubles as the output register. All stages advance
// together; a stalled response freezes the pipe and drops req.ready in the
// same cycle.
// ----------------------------------------------------------------------------
module sine_cosine_poly_approx #(
   parameter int PHASE_BITS    = scpa_pkg::DEF_PHASE_BITS,
   parameter int OUT_FRAC_BITS = scpa_pkg::DEF_OUT_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   scpa_req_if.sink   req,
   scpa_rsp_if.source rsp
);
   import scpa_pkg::*;

   localparam int M_W  = PHASE_BITS - 1;
   localparam int Q_W  = PHASE_BITS - 2;
   localparam int SH   = XF - OUT_FRAC_BITS;
   localparam int MG_W = A_W - SH + 1;
   localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << Q_W;

   logic              en;
   logic [STAGES-1:0] vld_ff;

   assign en        = !vld_ff[STAGES-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], req.valid};
      end
   end

   // quadrant fold
   logic [PHASE_BITS-1:0] ph;
   logic [1:0]            quad;
   logic [M_W-1:0]        m_in;
   logic [M_W-1:0]        m_ff;
   logic [STAGES-2:0]     neg_ff;

   assign ph   = req.phase + ((req.op == OP_COSINE) ? QUARTER : '0);
   assign quad = ph[PHASE_BITS-1 -: 2];
   assign m_in = quad[0] ? (M_W'(QUARTER) - M_W'(ph[Q_W-1:0])) : M_W'(ph[Q_W-1:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff   <= m_in;
         neg_ff <= {neg_ff[STAGES-3:0], quad[1]};
      end
   end

   // polynomial magnitude
   logic [A_W-1:0]  a_ff;
   logic [A2_W-1:0] a2_ff;
   logic [A3_W-1:0] a3_ff;
   logic [D_W-1:0]  d_ff;
   logic [T_W-1:0]  t_ff;
   logic [U_W-1:0]  u_ff;
   logic [A_W-1:0]  a3d_ff;
   logic [A_W-1:0]  a4d_ff;
   logic [A_W-1:0]  a5d_ff;
   logic [A_W-1:0]  a6d_ff;

   scpa_rmul #(.AW(M_W), .BW(TWOPI_W), .SHIFT(PHASE_BITS), .PW(A_W)) u_rad (
      .clock(clock), .en(en), .a(m_ff), .b(TWOPI_Q), .p_ff(a_ff)
   );

   scpa_rmul #(.AW(A_W), .BW(A_W), .SHIFT(XF), .PW(A2_W)) u_sq (
      .clock(clock), .en(en), .a(a_ff), .b(a_ff), .p_ff(a2_ff)
   );

   scpa_rmul #(.AW(A2_W), .BW(A_W), .SHIFT(XF), .PW(A3_W)) u_cube (
      .clock(clock), .en(en), .a(a2_ff), .b(a3d_ff), .p_ff(a3_ff)
   );

   scpa_rmul #(.AW(A3_W), .BW(D_W), .SHIFT(XF), .PW(T_W)) u_term (
      .clock(clock), .en(en), .a(a3_ff), .b(d_ff), .p_ff(t_ff)
   );

   scpa_rmul #(.AW(T_W), .BW(CQ_W), .SHIFT(XF), .PW(U_W)) u_coef (
      .clock(clock), .en(en), .a(t_ff), .b(C_Q), .p_ff(u_ff)
   );

   // a2 never reaches 20 on the folded range
   always_ff @(posedge clock) begin
      if (en) begin
         a3d_ff <= a_ff;
         a4d_ff <= a3d_ff;
         a5d_ff <= a4d_ff;
         a6d_ff <= a5d_ff;
         d_ff   <= TWENTY_Q - D_W'(a2_ff);
      end
   end

   // subtract, round, sign, saturate
   logic [A_W-1:0]            r;
   logic [A_W:0]              r_sum;
   logic [MG_W-1:0]           mag;
   logic signed [VALUE_W-1:0] value_in;
   logic signed [VALUE_W-1:0] value_ff;

   assign r     = (a6d_ff > A_W'(u_ff)) ? (a6d_ff - A_W'(u_ff)) : '0;
   assign r_sum = (A_W + 1)'(r) + ((A_W + 1)'(1) << (SH - 1));
   assign mag   = MG_W'(r_sum >> SH);

   always_comb begin
      priority if (!neg_ff[STAGES-2] && 32'(mag) > 32'd32767) begin
         value_in = VALUE_W'(32767);
      end else if (neg_ff[STAGES-2] && 32'(mag) > 32'd32768) begin
         value_in = VALUE_W'(-32768);
      end else if (neg_ff[STAGES-2]) begin
         value_in = VALUE_W'(-32'(mag));
      end else begin
         value_in = VALUE_W'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
      end
   end

   assign rsp.valid = vld_ff[STAGES-1];
   assign rsp.value = value_ff;

   // checks
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready))
      else $error("ready dropped without an output stall");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_term_below_angle: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES-2] |-> (A_W'(u_ff) <= a6d_ff))
      else $error("polynomial correction exceeds the angle");

endmodule

### sv/scpa_rmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_rmul
// Registered unsigned multiply with round-half-up right shift.
// ----------------------------------------------------------------------------
module scpa_rmul #(
   parameter int AW    = 16,
   parameter int BW    = 16,
   parameter int SHIFT = 8,
   parameter int PW    = 24
) (
   input  logic          clock,
   input  logic          en,
   input  logic [AW-1:0] a,
   input  logic [BW-1:0] b,
   output logic [PW-1:0] p_ff
);

   localparam int FW = AW + BW + 1;

   logic [FW-1:0] prod;
   logic [FW-1:0] sum;
   logic [PW-1:0] p_in;

   assign prod = FW'(a) * FW'(b);
   assign sum  = prod + (FW'(1) << (SHIFT - 1));
   assign p_in = PW'(sum >> SHIFT);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

endmodule
